/* sv/lwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared constants and types for the stream-prefetch cache tag controller.
// ----------------------------------------------------------------------------
package lwc_pkg;
  localparam int unsigned SETS         = 64;
  localparam int unsigned WAYS         = 4;
  localparam int unsigned BLOCK_BYTES  = 32;
  localparam int unsigned BUFFERS      = 4;
  localparam int unsigned BUFFER_DEPTH = 4;

  localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned IB     = $clog2(SETS);
  localparam int unsigned BLK_W  = 32 - OFF_W;
  localparam int unsigned TAG_W  = 32 - OFF_W - IB;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned BUF_W  = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;

  localparam logic [0:0] REG_PREFETCH_ON = 1'b0;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } line_t;

  typedef line_t [WAYS-1:0] set_row_t;
endpackage

/* sv/lwc_tag_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwc_tag_ram
// Tag, state and age storage, one row per set, with a registered read.
// Rows never written read as invalid through a per-set valid bit.
// ----------------------------------------------------------------------------
module lwc_tag_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lwc_pkg::SET_W-1:0] rd_set,
  output lwc_pkg::set_row_t         rd_row,
  input  logic                      wr_en,
  input  logic [lwc_pkg::SET_W-1:0] wr_set,
  input  lwc_pkg::set_row_t         wr_row
);
  lwc_pkg::set_row_t             mem [lwc_pkg::SETS];
  lwc_pkg::set_row_t             q_r;
  logic [lwc_pkg::SETS-1:0]      row_ok_r;
  logic                          ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    q_r <= mem[rd_set];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      ok_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_ok_r[wr_set] <= 1'b1;
      end
      ok_r <= row_ok_r[rd_set];
    end
  end

  always_comb begin
    rd_row = q_r;
    if (!ok_r) begin
      for (int w = 0; w < lwc_pkg::WAYS; w++) begin
        rd_row[w].valid = 1'b0;
        rd_row[w].dirty = 1'b0;
        rd_row[w].age   = '0;
      end
    end
  end
endmodule

/* sv/lru_writeback_cache_stream_prefetch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_cache_stream_prefetch
// Tag-only write-back cache controller with true LRU and stream buffers.
//
//   Channel  Direction  Signals
//   in_      input      in_valid, in_stall, in_action, in_addr
//   out_     output     out_valid, out_stall, hit, eviction, prefetch fields
//   cfg_     input      APB write/read of prefetch_on
//
// For each word the set row is read from the tag RAM on acceptance, then
// updated and written back in ST_UPDATE while the result is registered.
// A new word is accepted only in ST_IDLE and when the output register is
// empty or its result is taken in the same cycle.
// Reset is synchronous; all lines and buffers return to empty, buffer ranks to index order.
// ----------------------------------------------------------------------------
module lru_writeback_cache_stream_prefetch (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [31:0]                 in_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_cache_hit,
  output logic                        out_buffer_hit,
  output logic                        out_demand_miss,
  output logic [26:0]                 out_fetch_block,
  output logic                        out_evict_dirty,
  output logic [26:0]                 out_evict_block,
  output logic [26:0]                 out_prefetch_first,
  output logic [2:0]                  out_prefetch_count,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [0:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  localparam int unsigned BLK_W = lwc_pkg::BLK_W;
  localparam int unsigned TAG_W = lwc_pkg::TAG_W;
  localparam int unsigned SET_W = lwc_pkg::SET_W;
  localparam int unsigned BUF_W = lwc_pkg::BUF_W;

  lwc_pkg::state_t state_r, state_nxt;
  logic                 pf_on_r;
  logic                 act_r;
  logic [BLK_W-1:0]     blk_r;
  logic [BLK_W-1:0]     head_r  [lwc_pkg::BUFFERS];
  logic                 bval_r  [lwc_pkg::BUFFERS];
  logic [BUF_W-1:0]     rank_r  [lwc_pkg::BUFFERS];
  lwc_pkg::set_row_t    rd_row;
  lwc_pkg::set_row_t    wr_row;
  logic                 ov_r;
  logic                 o_ch_r, o_bh_r, o_dm_r, o_ed_r;
  logic [26:0]          o_fb_r, o_eb_r, o_pf_r;
  logic [2:0]           o_pc_r;
  logic                 in_acc, upd, out_free;
  logic [SET_W-1:0]     cur_set;
  logic [TAG_W-1:0]     cur_tag;

  // Item results computed in the update cycle.
  logic                 chit, bhit, ev_d;
  logic [BLK_W-1:0]     ev_blk, pf_first;
  logic [2:0]           pf_count;
  logic                 found;
  logic [BUF_W-1:0]     fbuf, lbuf, tbuf;
  logic                 touch_buf;
  logic [BLK_W-1:0]     hit_dist;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, pf_on_r};
  assign out_free   = !ov_r || !out_stall;
  assign in_stall   = (state_r != lwc_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign upd        = (state_r == lwc_pkg::ST_UPDATE);
  assign cur_set    = SET_W'(blk_r);
  assign cur_tag    = TAG_W'(blk_r >> lwc_pkg::IB);

  lwc_tag_ram u_tag_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_set (SET_W'(in_addr >> lwc_pkg::OFF_W)),
    .rd_row (rd_row),
    .wr_en  (upd),
    .wr_set (cur_set),
    .wr_row (wr_row)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lwc_pkg::ST_IDLE:   if (in_acc) state_nxt = lwc_pkg::ST_UPDATE;
      lwc_pkg::ST_UPDATE: state_nxt = lwc_pkg::ST_IDLE;
      default:            state_nxt = lwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    logic [lwc_pkg::WAY_W-1:0] way, hway, fway, away;
    logic                      hfound, ffound;
    logic [lwc_pkg::AGE_W:0]   old_age;
    logic [lwc_pkg::AGE_W-1:0] best;
    hway = '0; hfound = 1'b0; fway = '0; ffound = 1'b0;
    away = '0; best = '0;
    ev_d = 1'b0; ev_blk = '0;
    for (int w = 0; w < lwc_pkg::WAYS; w++) begin
      if (!hfound && rd_row[w].valid && rd_row[w].tag == cur_tag) begin
        hfound = 1'b1;
        hway   = lwc_pkg::WAY_W'(w);
      end
      if (!ffound && !rd_row[w].valid) begin
        ffound = 1'b1;
        fway   = lwc_pkg::WAY_W'(w);
      end
      if (rd_row[w].age >= best) begin
        best = rd_row[w].age;
        away = lwc_pkg::WAY_W'(w);
      end
    end
    chit = hfound;
    wr_row = rd_row;
    if (hfound) begin
      way     = hway;
      old_age = {1'b0, rd_row[hway].age};
    end else if (ffound) begin
      way     = fway;
      old_age = (lwc_pkg::AGE_W+1)'(lwc_pkg::WAYS);
    end else begin
      way     = away;
      old_age = {1'b0, rd_row[away].age};
      if (rd_row[away].dirty) begin
        ev_d   = 1'b1;
        ev_blk = BLK_W'({rd_row[away].tag, cur_set});
      end
    end
    for (int w = 0; w < lwc_pkg::WAYS; w++) begin
      if (lwc_pkg::WAY_W'(w) != way && rd_row[w].valid &&
          {1'b0, rd_row[w].age} < old_age) begin
        wr_row[w].age = rd_row[w].age + 1'b1;
      end
    end
    wr_row[way].age = '0;
    if (hfound) begin
      if (act_r) wr_row[way].dirty = 1'b1;
    end else begin
      wr_row[way].valid = 1'b1;
      wr_row[way].dirty = act_r;
      wr_row[way].tag   = cur_tag;
    end
  end

  always_comb begin
    logic [BLK_W-1:0] d;
    found = 1'b0; fbuf = '0; lbuf = '0; hit_dist = '0;
    for (int r = 0; r < lwc_pkg::BUFFERS; r++) begin
      for (int b = 0; b < lwc_pkg::BUFFERS; b++) begin
        d = blk_r - head_r[b];
        if (!found && rank_r[b] == BUF_W'(r) && bval_r[b] &&
            d < BLK_W'(lwc_pkg::BUFFER_DEPTH)) begin
          found    = 1'b1;
          fbuf     = BUF_W'(b);
          hit_dist = d;
        end
      end
    end
    for (int b = 0; b < lwc_pkg::BUFFERS; b++) begin
      if (rank_r[b] == BUF_W'(lwc_pkg::BUFFERS - 1)) lbuf = BUF_W'(b);
    end
    bhit = 1'b0; pf_first = '0; pf_count = '0; touch_buf = 1'b0; tbuf = lbuf;
    if (pf_on_r) begin
      if (found) begin
        bhit      = 1'b1;
        touch_buf = 1'b1;
        tbuf      = fbuf;
        pf_first  = head_r[fbuf] + BLK_W'(lwc_pkg::BUFFER_DEPTH);
        pf_count  = 3'(hit_dist + 1'b1);
      end else if (!chit) begin
        touch_buf = 1'b1;
        tbuf      = lbuf;
        pf_first  = blk_r + 1'b1;
        pf_count  = 3'(lwc_pkg::BUFFER_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      blk_r <= BLK_W'(in_addr >> lwc_pkg::OFF_W);
    end
    if (upd) begin
      o_ch_r <= chit;
      o_bh_r <= bhit;
      o_dm_r <= !chit && !bhit;
      o_fb_r <= (!chit && !bhit) ? 27'(blk_r) : '0;
      o_ed_r <= ev_d;
      o_eb_r <= 27'(ev_blk);
      o_pf_r <= 27'(pf_first);
      o_pc_r <= pf_count;
    end
    if (upd && touch_buf) begin
      head_r[tbuf] <= blk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwc_pkg::ST_IDLE;
      pf_on_r <= 1'b0;
      ov_r    <= 1'b0;
      for (int b = 0; b < lwc_pkg::BUFFERS; b++) begin
        bval_r[b] <= 1'b0;
        rank_r[b] <= BUF_W'(b);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == lwc_pkg::REG_PREFETCH_ON) begin
        pf_on_r <= cfg_pwdata[0];
      end
      if (upd) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (upd && touch_buf) begin
        bval_r[tbuf] <= 1'b1;
        for (int b = 0; b < lwc_pkg::BUFFERS; b++) begin
          if (BUF_W'(b) != tbuf && rank_r[b] < rank_r[tbuf]) begin
            rank_r[b] <= rank_r[b] + 1'b1;
          end
        end
        rank_r[tbuf] <= '0;
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_cache_hit      = o_ch_r;
  assign out_buffer_hit     = o_bh_r;
  assign out_demand_miss    = o_dm_r;
  assign out_fetch_block    = o_fb_r;
  assign out_evict_dirty    = o_ed_r;
  assign out_evict_block    = o_eb_r;
  assign out_prefetch_first = o_pf_r;
  assign out_prefetch_count = o_pc_r;
endmodule

/* bench/lru_writeback_cache_stream_prefetch_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_cache_stream_prefetch_tb
// Drives read and write words into the cache tag controller and checks every
// result against a predictor of the cache lines, the true-LRU ages and the
// stream buffers. Prefetching is switched off and on between phases, and in
// all phases but one both sides idle and stall at random.
// ----------------------------------------------------------------------------
module lru_writeback_cache_stream_prefetch_tb;

  typedef struct packed {
    logic        cache_hit;
    logic        buffer_hit;
    logic        demand_miss;
    logic [26:0] fetch_block;
    logic        evict_dirty;
    logic [26:0] evict_block;
    logic [26:0] prefetch_first;
    logic [2:0]  prefetch_count;
  } access_result_t;

  class cache_scoreboard;
    logic [lwc_pkg::TAG_W-1:0] tag_mem [lwc_pkg::SETS*lwc_pkg::WAYS];
    bit                        valid_mem [lwc_pkg::SETS*lwc_pkg::WAYS];
    bit                        dirty_mem [lwc_pkg::SETS*lwc_pkg::WAYS];
    int                        age_mem [lwc_pkg::SETS*lwc_pkg::WAYS];
    logic [lwc_pkg::BLK_W-1:0] head_mem [lwc_pkg::BUFFERS];
    bit                        head_valid [lwc_pkg::BUFFERS];
    int                        rank_mem [lwc_pkg::BUFFERS];
    bit                        prefetch;
    access_result_t            expected_mem [4096];
    int                        wr_count;
    int                        rd_count;
    int                        mismatches;

    function void clear();
      for (int i = 0; i < lwc_pkg::SETS*lwc_pkg::WAYS; i++) begin
        valid_mem[i] = 0;
        dirty_mem[i] = 0;
        age_mem[i] = 0;
      end
      for (int b = 0; b < lwc_pkg::BUFFERS; b++) begin
        head_valid[b] = 0;
        rank_mem[b] = b;
      end
      prefetch = 0;
      wr_count = 0;
      rd_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return wr_count - rd_count;
    endfunction

    function void touch(int base, int way, int old_age);
      for (int w = 0; w < lwc_pkg::WAYS; w++)
        if (w != way && valid_mem[base+w] && age_mem[base+w] < old_age)
          age_mem[base+w]++;
      age_mem[base+way] = 0;
    endfunction

    function void promote(int b);
      int r;
      r = rank_mem[b];
      for (int i = 0; i < lwc_pkg::BUFFERS; i++)
        if (i != b && rank_mem[i] < r) rank_mem[i]++;
      rank_mem[b] = 0;
    endfunction

    function void note_word(bit is_write, logic [31:0] addr);
      access_result_t            r;
      logic [lwc_pkg::BLK_W-1:0] blk, gap;
      logic [lwc_pkg::TAG_W-1:0] tag;
      int                        set, base, way, old_age, best, found, lru;
      r = '0;
      blk = addr[31:lwc_pkg::OFF_W];
      set = blk[lwc_pkg::IB-1:0];
      tag = addr[31:lwc_pkg::OFF_W+lwc_pkg::IB];
      base = set * lwc_pkg::WAYS;
      way = lwc_pkg::WAYS;
      for (int w = 0; w < lwc_pkg::WAYS; w++)
        if (way == lwc_pkg::WAYS && valid_mem[base+w] && tag_mem[base+w] == tag)
          way = w;
      if (way < lwc_pkg::WAYS) begin
        r.cache_hit = 1;
        touch(base, way, age_mem[base+way]);
        if (is_write) dirty_mem[base+way] = 1;
      end else begin
        old_age = lwc_pkg::WAYS;
        for (int w = 0; w < lwc_pkg::WAYS; w++)
          if (way == lwc_pkg::WAYS && !valid_mem[base+w]) way = w;
        if (way == lwc_pkg::WAYS) begin
          best = 0;
          way = 0;
          for (int w = 0; w < lwc_pkg::WAYS; w++)
            if (age_mem[base+w] >= best) begin
              best = age_mem[base+w];
              way = w;
            end
          old_age = age_mem[base+way];
          if (dirty_mem[base+way]) begin
            r.evict_dirty = 1;
            r.evict_block = {tag_mem[base+way], set[lwc_pkg::IB-1:0]};
          end
        end
        valid_mem[base+way] = 1;
        dirty_mem[base+way] = is_write;
        tag_mem[base+way] = tag;
        touch(base, way, old_age);
      end
      if (prefetch) begin
        found = lwc_pkg::BUFFERS;
        for (int rk = 0; rk < lwc_pkg::BUFFERS && found == lwc_pkg::BUFFERS; rk++)
          for (int b = 0; b < lwc_pkg::BUFFERS; b++)
            if (rank_mem[b] == rk) begin
              if (head_valid[b]) begin
                gap = blk - head_mem[b];
                if (gap < lwc_pkg::BUFFER_DEPTH) begin
                  found = b;
                  r.prefetch_first = 27'(head_mem[b] + lwc_pkg::BUFFER_DEPTH);
                  r.prefetch_count = 3'(gap + 1);
                end
              end
              break;
            end
        if (found < lwc_pkg::BUFFERS) begin
          r.buffer_hit = 1;
          head_mem[found] = lwc_pkg::BLK_W'(blk + 1);
          promote(found);
        end else if (!r.cache_hit) begin
          lru = 0;
          for (int b = 0; b < lwc_pkg::BUFFERS; b++)
            if (rank_mem[b] == lwc_pkg::BUFFERS - 1) lru = b;
          head_mem[lru] = lwc_pkg::BLK_W'(blk + 1);
          head_valid[lru] = 1;
          promote(lru);
          r.prefetch_first = head_mem[lru];
          r.prefetch_count = 3'(lwc_pkg::BUFFER_DEPTH);
        end
      end
      r.demand_miss = !r.cache_hit && !r.buffer_hit;
      if (r.demand_miss) r.fetch_block = blk;
      expected_mem[wr_count % $size(expected_mem)] = r;
      wr_count++;
    endfunction

    function void check_result(access_result_t got);
      access_result_t want;
      if (pending() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", got);
        return;
      end
      want = expected_mem[rd_count % $size(expected_mem)];
      rd_count++;
      if (got.cache_hit !== want.cache_hit || got.buffer_hit !== want.buffer_hit ||
          got.demand_miss !== want.demand_miss || got.fetch_block !== want.fetch_block ||
          got.evict_dirty !== want.evict_dirty || got.evict_block !== want.evict_block ||
          got.prefetch_first !== want.prefetch_first ||
          got.prefetch_count !== want.prefetch_count) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_action = 0;
  logic [31:0] in_addr = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_cache_hit, out_buffer_hit, out_demand_miss, out_evict_dirty;
  logic [26:0] out_fetch_block, out_evict_block, out_prefetch_first;
  logic [2:0]  out_prefetch_count;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cache_scoreboard sb = new();
  bit idle_on = 1;
  int hold_left = 0;

  lru_writeback_cache_stream_prefetch dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_cache_hit, out_buffer_hit, out_demand_miss, out_fetch_block,
                       out_evict_dirty, out_evict_block, out_prefetch_first,
                       out_prefetch_count});
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 33);
    end
  end

  task automatic send_word(bit is_write, logic [31:0] addr);
    if (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= is_write;
    in_addr <= addr;
    do @(posedge clk); while (in_stall);
    sb.note_word(is_write, addr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_prefetch(bit v);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= lwc_pkg::REG_PREFETCH_ON;
    cfg_pwdata <= {31'b0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.prefetch = v;
  endtask

  task automatic random_phase(int count);
    logic [31:0] addr;
    int          mode, run, stride;
    while (count > 0) begin
      mode = $urandom_range(9);
      if (mode < 5) begin
        addr = $urandom();
        run = $urandom_range(3, 10);
        stride = $urandom_range(1, 2);
        for (int i = 0; i < run && count > 0; i++) begin
          send_word(1'($urandom_range(1)), addr + i * stride * lwc_pkg::BLOCK_BYTES +
                    $urandom_range(lwc_pkg::BLOCK_BYTES - 1));
          count--;
        end
      end else if (mode < 9) begin
        addr = ({21'($urandom_range(7)), 6'($urandom_range(3))} << lwc_pkg::OFF_W) |
               $urandom_range(lwc_pkg::BLOCK_BYTES - 1);
        send_word(1'($urandom_range(1)), addr);
        count--;
      end else begin
        send_word(1'($urandom_range(1)), $urandom());
        count--;
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_prefetch(1'b0);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b0, 32'hFFFF_FFFF);
    for (int t = 1; t <= 5; t++) send_word(1'b1, t << (lwc_pkg::OFF_W + lwc_pkg::IB));
    send_word(1'b0, 32'h0000_0800);
    drain();
    write_prefetch(1'b1);
    send_word(1'b0, 32'h1000_0000);
    send_word(1'b0, 32'h1000_0020);
    send_word(1'b1, 32'h1000_0060);
    send_word(1'b0, 32'h1000_00A0);
    send_word(1'b0, 32'hFFFF_FFE0);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b0, 32'h1000_0020);
    send_word(1'b0, 32'h7FFF_FFFF);
    send_word(1'b1, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_prefetch(ph % 4 != 0);
      idle_on = (ph != 3);
      if (ph == 5) hold_left = 300;
      random_phase(200);
      if (ph == 6) begin
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        random_phase(20);
      end
      drain();
    end
    idle_on = 1;
    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

/* files.f */
sv/lwc_pkg.sv
sv/lwc_tag_ram.sv
sv/lru_writeback_cache_stream_prefetch.sv
bench/lru_writeback_cache_stream_prefetch_tb.sv
